/* design/rfb_server_stream_deframer_macros.svh */
// Assertion helpers for the RFB stream deframer.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RFB_SERVER_STREAM_DEFRAMER_MACROS_SVH
`define RFB_SERVER_STREAM_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RFB_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rfb deframer check failed");
`define RFB_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rfb deframer check failed");
`else
`define RFB_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define RFB_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

/* design/rfb_ssd_pkg.sv */
`default_nettype none
package rfb_ssd_pkg;

  localparam int PIX_CNT_BITS_DEF = 48;

  localparam logic [5:0] BPP_RESET = 6'd32;

  // Server message type codes.
  localparam logic [7:0] MSG_FB_UPDATE = 8'd0;
  localparam logic [7:0] MSG_CMAP      = 8'd1;
  localparam logic [7:0] MSG_BELL      = 8'd2;
  localparam logic [7:0] MSG_CUT       = 8'd3;

  // Header byte index of the final byte of each header, and the rectangle field byte count.
  localparam logic [3:0] UPD_HDR_LAST     = 4'd2;
  localparam logic [3:0] RECT_HDR_LAST    = 4'd11;
  localparam logic [3:0] RECT_FIELD_BYTES = 4'd8;
  localparam logic [3:0] CMAP_HDR_LAST    = 4'd4;
  localparam logic [3:0] CUT_HDR_LAST     = 4'd6;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_UPD    = 3'd1,
    PH_RHDR   = 3'd2,
    PH_RDATA  = 3'd3,
    PH_CMHDR  = 3'd4,
    PH_CUTHDR = 3'd5,
    PH_SKIP   = 3'd6,
    PH_ERR    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_HDR  = 3'd0,
    EV_PIX  = 3'd1,
    EV_RECT = 3'd2,
    EV_UPD  = 3'd3,
    EV_BELL = 3'd4,
    EV_SKIP = 3'd5,
    EV_BAD  = 3'd6,
    EV_IGN  = 3'd7
  } event_t;

  typedef struct packed {
    logic   step;
    logic   shift_hdr;
    logic   shift_rect;
    logic   load_wh;
    logic   load_rects;
    logic   load_enc;
    logic   load_nb;
    logic   load_cmap;
    logic   load_cut;
    logic   dec_bytes;
    logic   finish;
    logic   add_pix;
    logic   inc_upd;
    event_t ev;
    logic   pass_byte;
    logic   rect_done;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       cnt16_zero;
    logic       cut_zero;
    logic       nb_zero;
    logic       enc_zero;
    logic       new_enc_zero;
    logic       bytes_last;
    logic       rects_last;
  } dp_sts_t;

endpackage
`default_nettype wire

/* design/rfb_ssd_dp.sv */
`default_nettype none
module rfb_ssd_dp #(
  parameter int PIXEL_COUNT_BITS = rfb_ssd_pkg::PIX_CNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [5:0]            cfg_wr_data,
  input  wire logic [7:0]            in_stream_byte,
  input  wire rfb_ssd_pkg::dp_cmd_t  cmd,
  output rfb_ssd_pkg::dp_sts_t       sts,
  output logic [2:0]                 out_event_res,
  output logic [7:0]                 out_pixel_byte,
  output logic                       out_rect_done,
  output logic [15:0]                out_rect_x,
  output logic [15:0]                out_rect_y,
  output logic [15:0]                out_rect_w,
  output logic [15:0]                out_rect_h,
  output logic signed [31:0]         out_rect_encoding,
  output logic [31:0]                out_updates_done,
  output logic [47:0]                out_pixels_done
);
  import rfb_ssd_pkg::*;

  logic [5:0]                  bpp_r;
  logic [31:0]                 hs_r, hs_nxt;
  logic [63:0]                 rf_r, rf_nxt;
  logic [31:0]                 wh_r, wh_nxt;
  logic [31:0]                 enc_r, enc_nxt;
  logic [15:0]                 rects_r, rects_nxt;
  logic [34:0]                 bytes_r, bytes_nxt;
  logic [31:0]                 upd_r, upd_nxt;
  logic [PIXEL_COUNT_BITS-1:0] pix_r, pix_nxt;
  event_t                      ev_r, ev_nxt;
  logic [7:0]                  pb_r, pb_nxt;
  logic                        rd_r, rd_nxt;

  logic [31:0]                 new_hs;
  logic [6:0]                  bpp_sum;
  logic [3:0]                  bypp;
  logic [35:0]                 nb_full;
  logic [34:0]                 nb;
  logic [18:0]                 cmap_bytes;
  logic [PIXEL_COUNT_BITS:0]   pix_sum;
  logic [63:0]                 pix_ext;

  assign new_hs     = {hs_r[23:0], in_stream_byte};
  assign bpp_sum    = {1'b0, bpp_r} + 7'd7;
  assign bypp       = bpp_sum[6:3];
  assign nb_full    = wh_r * bypp;
  assign nb         = nb_full[34:0];
  // Six bytes per colour-map entry.
  assign cmap_bytes = {1'b0, new_hs[15:0], 2'b00} + {2'b00, new_hs[15:0], 1'b0};
  assign pix_sum    = {1'b0, pix_r} + (PIXEL_COUNT_BITS + 1)'(wh_r);

  always_comb begin
    sts.in_byte      = in_stream_byte;
    sts.cnt16_zero   = (new_hs[15:0] == 16'd0);
    sts.cut_zero     = new_hs[31] || (new_hs == 32'd0);
    sts.nb_zero      = (nb == 35'd0);
    sts.enc_zero     = (enc_r == 32'd0);
    sts.new_enc_zero = (new_hs == 32'd0);
    sts.bytes_last   = (bytes_r == 35'd1);
    sts.rects_last   = (rects_r == 16'd1);
  end

  always_comb begin
    hs_nxt    = hs_r;
    rf_nxt    = rf_r;
    wh_nxt    = wh_r;
    enc_nxt   = enc_r;
    rects_nxt = rects_r;
    bytes_nxt = bytes_r;
    upd_nxt   = upd_r;
    pix_nxt   = pix_r;
    ev_nxt    = ev_r;
    pb_nxt    = pb_r;
    rd_nxt    = rd_r;
    if (cmd.step) begin
      ev_nxt = cmd.ev;
      pb_nxt = cmd.pass_byte ? in_stream_byte : 8'd0;
      rd_nxt = cmd.rect_done;
      if (cmd.shift_hdr) begin
        hs_nxt = new_hs;
      end
      if (cmd.shift_rect) begin
        rf_nxt = {rf_r[55:0], in_stream_byte};
      end
      if (cmd.load_wh) begin
        wh_nxt = rf_r[31:16] * rf_r[15:0];
      end
      if (cmd.load_enc) begin
        enc_nxt = new_hs;
      end
      if (cmd.load_rects) begin
        rects_nxt = new_hs[15:0];
      end else if (cmd.finish) begin
        rects_nxt = rects_r - 16'd1;
      end
      priority if (cmd.load_nb) begin
        bytes_nxt = nb;
      end else if (cmd.load_cmap) begin
        bytes_nxt = 35'(cmap_bytes);
      end else if (cmd.load_cut) begin
        bytes_nxt = new_hs[31] ? 35'd0 : 35'(new_hs);
      end else if (cmd.dec_bytes) begin
        bytes_nxt = bytes_r - 35'd1;
      end
      if (cmd.inc_upd) begin
        upd_nxt = upd_r + 32'd1;
      end
      // The carry out of the add means the counter saturates.
      if (cmd.finish && cmd.add_pix) begin
        pix_nxt = pix_sum[PIXEL_COUNT_BITS] ? '1 : pix_sum[PIXEL_COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_RESET;
      hs_r    <= '0;
      rf_r    <= '0;
      wh_r    <= '0;
      enc_r   <= '0;
      rects_r <= '0;
      bytes_r <= '0;
      upd_r   <= '0;
      pix_r   <= '0;
      ev_r    <= EV_HDR;
      pb_r    <= '0;
      rd_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bpp_r <= cfg_wr_data;
      end
      hs_r    <= hs_nxt;
      rf_r    <= rf_nxt;
      wh_r    <= wh_nxt;
      enc_r   <= enc_nxt;
      rects_r <= rects_nxt;
      bytes_r <= bytes_nxt;
      upd_r   <= upd_nxt;
      pix_r   <= pix_nxt;
      ev_r    <= ev_nxt;
      pb_r    <= pb_nxt;
      rd_r    <= rd_nxt;
    end
  end

  assign pix_ext           = 64'(pix_r);
  assign out_event_res     = 3'(ev_r);
  assign out_pixel_byte    = pb_r;
  assign out_rect_done     = rd_r;
  assign out_rect_x        = rf_r[63:48];
  assign out_rect_y        = rf_r[47:32];
  assign out_rect_w        = rf_r[31:16];
  assign out_rect_h        = rf_r[15:0];
  assign out_rect_encoding = signed'(enc_r);
  assign out_updates_done  = upd_r;
  assign out_pixels_done   = pix_ext[47:0];

endmodule
`default_nettype wire

/* design/rfb_ssd_ctrl.sv */
`default_nettype none
`include "rfb_server_stream_deframer_macros.svh"
module rfb_ssd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_stall,
  input  wire rfb_ssd_pkg::dp_sts_t sts,
  output rfb_ssd_pkg::dp_cmd_t   cmd,
  output logic                   in_stall,
  output logic                   out_valid
);
  import rfb_ssd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // A new request may enter whenever the result register is empty or drains.
  assign in_stall      = out_valid_r && out_stall;
  assign accept        = in_valid && !in_stall;
  assign out_valid_nxt = accept || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (accept) begin
      unique case (phase_r)
        PH_TYPE: begin
          idx_nxt = '0;
          unique case (sts.in_byte)
            MSG_FB_UPDATE: phase_nxt = PH_UPD;
            MSG_CMAP:      phase_nxt = PH_CMHDR;
            MSG_BELL:      phase_nxt = PH_TYPE;
            MSG_CUT:       phase_nxt = PH_CUTHDR;
            default:       phase_nxt = PH_ERR;
          endcase
        end
        PH_UPD: begin
          if (idx_r == UPD_HDR_LAST) begin
            idx_nxt   = '0;
            phase_nxt = sts.cnt16_zero ? PH_TYPE : PH_RHDR;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        PH_RHDR: begin
          if (idx_r == RECT_HDR_LAST) begin
            idx_nxt = '0;
            if (sts.nb_zero) begin
              phase_nxt = sts.rects_last ? PH_TYPE : PH_RHDR;
            end else begin
              phase_nxt = PH_RDATA;
            end
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        PH_RDATA: begin
          if (sts.bytes_last) begin
            phase_nxt = sts.rects_last ? PH_TYPE : PH_RHDR;
          end
        end
        PH_CMHDR: begin
          if (idx_r == CMAP_HDR_LAST) begin
            idx_nxt   = '0;
            phase_nxt = sts.cnt16_zero ? PH_TYPE : PH_SKIP;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        PH_CUTHDR: begin
          if (idx_r == CUT_HDR_LAST) begin
            idx_nxt   = '0;
            phase_nxt = sts.cut_zero ? PH_TYPE : PH_SKIP;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        PH_SKIP: begin
          if (sts.bytes_last) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_ERR: begin
          phase_nxt = PH_ERR;
        end
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.step = accept;
    cmd.ev   = EV_HDR;
    unique case (phase_r)
      PH_TYPE: begin
        unique case (sts.in_byte)
          MSG_FB_UPDATE: cmd.ev = EV_HDR;
          MSG_CMAP:      cmd.ev = EV_HDR;
          MSG_BELL:      cmd.ev = EV_BELL;
          MSG_CUT:       cmd.ev = EV_HDR;
          default:       cmd.ev = EV_BAD;
        endcase
      end
      PH_UPD: begin
        cmd.shift_hdr = 1'b1;
        if (idx_r == UPD_HDR_LAST) begin
          cmd.load_rects = 1'b1;
          if (sts.cnt16_zero) begin
            cmd.inc_upd = 1'b1;
            cmd.ev      = EV_UPD;
          end
        end
      end
      PH_RHDR: begin
        cmd.shift_rect = (idx_r < RECT_FIELD_BYTES);
        cmd.shift_hdr  = !(idx_r < RECT_FIELD_BYTES);
        cmd.load_wh    = (idx_r == RECT_FIELD_BYTES);
        if (idx_r == RECT_HDR_LAST) begin
          cmd.load_enc = 1'b1;
          cmd.ev       = EV_RECT;
          if (sts.nb_zero) begin
            // An empty rectangle completes on its last header byte.
            cmd.rect_done = 1'b1;
            cmd.finish    = 1'b1;
            cmd.add_pix   = sts.new_enc_zero;
            if (sts.rects_last) begin
              cmd.inc_upd = 1'b1;
              cmd.ev      = EV_UPD;
            end
          end else begin
            cmd.load_nb = 1'b1;
          end
        end
      end
      PH_RDATA: begin
        cmd.pass_byte = sts.enc_zero;
        cmd.ev        = sts.enc_zero ? EV_PIX : EV_SKIP;
        cmd.dec_bytes = 1'b1;
        if (sts.bytes_last) begin
          cmd.rect_done = 1'b1;
          cmd.finish    = 1'b1;
          cmd.add_pix   = sts.enc_zero;
          if (sts.rects_last) begin
            cmd.inc_upd = 1'b1;
            cmd.ev      = EV_UPD;
          end
        end
      end
      PH_CMHDR: begin
        cmd.shift_hdr = 1'b1;
        cmd.load_cmap = (idx_r == CMAP_HDR_LAST);
      end
      PH_CUTHDR: begin
        cmd.shift_hdr = 1'b1;
        cmd.load_cut  = (idx_r == CUT_HDR_LAST);
      end
      PH_SKIP: begin
        cmd.ev        = EV_SKIP;
        cmd.dec_bytes = 1'b1;
      end
      PH_ERR: begin
        cmd.ev = EV_IGN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RFB_ASSERT_NXT(a_err_sticky, clk, rst_n, phase_r == PH_ERR, phase_r == PH_ERR)
  `RFB_ASSERT_IMP(a_idx_idle, clk, rst_n,
                  phase_r == PH_TYPE || phase_r == PH_RDATA || phase_r == PH_SKIP,
                  idx_r == 4'd0)
  `RFB_ASSERT_NXT(a_last_rect, clk, rst_n,
                  accept && phase_r == PH_RDATA && sts.bytes_last && sts.rects_last,
                  phase_r == PH_TYPE)
  `RFB_ASSERT_IMP(a_idx_range, clk, rst_n, phase_r == PH_RHDR, idx_r <= RECT_HDR_LAST)

endmodule
`default_nettype wire

/* design/rfb_server_stream_deframer.sv */
`default_nettype none
// RFB server-to-client stream deframer.
// Input: one stream byte per request on in_valid/in_stall/in_stream_byte.
// Output: exactly one result per input byte on out_valid/out_stall, giving
// an event code, the pixel byte of raw rectangles, a rectangle-done flag,
// the current rectangle header fields and the update and pixel counters.
// Configuration: cfg_wr_en writes cfg_wr_data into bits_per_pixel.
// The result of an accepted byte is registered and valid in the next cycle.
// Throughput is one byte per cycle while in_stall is low; each byte is parsed in a
// single pass of the controller state machine and the header shift registers.
// The result register holds while out_stall is high, and in_stall rises
// only while a held result is still waiting, so no request is lost.
// Reset clears the parser to wait for a message type, clears all counters
// and the error state, and sets bits_per_pixel to 32. After an unknown
// message type every byte reports "ignored" until the next reset.
module rfb_server_stream_deframer #(
  parameter int PIXEL_COUNT_BITS = rfb_ssd_pkg::PIX_CNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [5:0]    cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_stream_byte,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_event_res,
  output logic [7:0]         out_pixel_byte,
  output logic               out_rect_done,
  output logic [15:0]        out_rect_x,
  output logic [15:0]        out_rect_y,
  output logic [15:0]        out_rect_w,
  output logic [15:0]        out_rect_h,
  output logic signed [31:0] out_rect_encoding,
  output logic [31:0]        out_updates_done,
  output logic [47:0]        out_pixels_done
);
  import rfb_ssd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rfb_ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  rfb_ssd_dp #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_stream_byte    (in_stream_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_event_res     (out_event_res),
    .out_pixel_byte    (out_pixel_byte),
    .out_rect_done     (out_rect_done),
    .out_rect_x        (out_rect_x),
    .out_rect_y        (out_rect_y),
    .out_rect_w        (out_rect_w),
    .out_rect_h        (out_rect_h),
    .out_rect_encoding (out_rect_encoding),
    .out_updates_done  (out_updates_done),
    .out_pixels_done   (out_pixels_done)
  );

endmodule
`default_nettype wire
